@@ design/dbvs_pkg.sv @@
// ---------------------------------------------------------------------------
// dbvs_pkg: shared types and constants for the diving branch selector
// Fixed-point format, payload words, queue record and register indexes.
// ---------------------------------------------------------------------------
package dbvs_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int COLUMN_BITS = 20;
    localparam int VAL_BITS    = 56;
    localparam int LOCK_BITS   = 16;
    localparam int PRIO_BITS   = 16;
    localparam int TOL_BITS    = 24;
    localparam int KEY_BITS    = FRAC_BITS + 11;
    localparam int RANK_BITS   = LOCK_BITS + 1;
    localparam int DIST_BITS   = FRAC_BITS + 1;
    localparam int TOL_CMP_W   = (DIST_BITS > TOL_BITS) ? DIST_BITS : TOL_BITS;
    localparam int SCALE_BITS  = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SCALE_BITS-1:0] KEY_SCALE = SCALE_BITS'(1000);
    localparam logic [RANK_BITS-1:0]  RANK_SENT = '1;
    localparam logic [KEY_BITS-1:0]   KEY_SENT  = '1;
    localparam logic [TOL_BITS-1:0]   TOL_RESET = TOL_BITS'(17);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = TOL_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIO_EN   = CFG_IDX_BITS'(1);

    // direction_code bits
    localparam int DIR_FORCE = 0;
    localparam int DIR_UP    = 1;

    typedef struct packed {
        logic [COLUMN_BITS-1:0]     column_index;
        logic signed [VAL_BITS-1:0] lp_value;
        logic signed [VAL_BITS-1:0] lower_bound;
        logic signed [VAL_BITS-1:0] upper_bound;
        logic                       heuristic_integer;
        logic                       binary_flag;
        logic [LOCK_BITS-1:0]       down_locks;
        logic [LOCK_BITS-1:0]       up_locks;
        logic [PRIO_BITS-1:0]       item_priority;
        logic [1:0]                 direction_code;
        logic                       last_item;
    } cand_t;

    typedef struct packed {
        logic                   found;
        logic [COLUMN_BITS-1:0] best_column;
        logic                   round_up;
        logic                   all_trivially_roundable;
    } result_t;

    // classified candidate, front to back
    typedef struct packed {
        logic                   cand;
        logic                   both;
        logic                   up;
        logic [KEY_BITS-1:0]    key;
        logic [LOCK_BITS-1:0]   locks;
        logic [PRIO_BITS-1:0]   prio;
        logic [1:0]             dir;
        logic [COLUMN_BITS-1:0] column;
        logic                   last;
    } cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ design/dive_branch_variable_select_top.sv @@
// ---------------------------------------------------------------------------
// dive_branch_variable_select_top: branching-variable selector for diving
// Classifier, queue and ranking stage; configuration registers.
// ---------------------------------------------------------------------------
//  channel  handshake              word
//  cand     cand_valid/cand_stall  cand_t, one candidate
//  res      res_valid/res_stall    result_t, one per scan (on last candidate)
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One candidate per cycle while cand_stall is low; a scan's result word
//  becomes valid once its last candidate has passed the classifier
//  register, the queue and the result register.
//  The queue lets candidates keep flowing while a result waits on res_stall;
//  only a last candidate waits in the queue for the result register.
//  Reset loads tolerance 17, priorities off and an empty scan.
// ---------------------------------------------------------------------------
module dive_branch_variable_select_top
    import dbvs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cand_valid,
    output logic                     cand_stall,
    input  cand_t                    cand,
    output logic                     res_valid,
    input  logic                     res_stall,
    output result_t                  res,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [TOL_BITS-1:0] tolerance_reg;
    logic                prio_en_reg;
    logic                cfg_write;
    logic                q_push;
    logic                q_pop;
    cls_t                q_in;
    cls_t                q_head;
    q_status_t           q_stat;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
            prio_en_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TOLERANCE: tolerance_reg <= cfg_data[TOL_BITS-1:0];
                REG_PRIO_EN:   prio_en_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    dbvs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand       (cand),
        .tolerance  (tolerance_reg),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_word  (q_in)
    );

    dbvs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    dbvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .prio_en   (prio_en_reg),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> (res.best_column == '0 && !res.round_up))
        else $error("result without choice carries a column");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cand_stall |-> q_stat.full)
        else $error("candidate stalled with room in queue");
`endif

endmodule

@@ design/dbvs_front.sv @@
// ---------------------------------------------------------------------------
// dbvs_front: candidate classifier
// Checks bounds and integrality, picks the natural direction and builds the
// distance key; registers the classified word for the queue.
// ---------------------------------------------------------------------------
module dbvs_front
    import dbvs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cand_valid,
    output logic                cand_stall,
    input  cand_t               cand,
    input  logic [TOL_BITS-1:0] tolerance,
    input  q_status_t           q_stat,
    output logic                push,
    output cls_t                push_word
);

    localparam logic [DIST_BITS-1:0] ONE  = DIST_BITS'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic                 front_valid_reg;
    logic                 front_valid_next;
    cls_t                 front_reg;
    cls_t                 front_next;
    logic                 advance;
    logic                 accept;
    logic [FRAC_BITS-1:0] frac;
    logic [DIST_BITS-1:0] frac_ext;
    logic [DIST_BITS-1:0] dist_near;
    logic [DIST_BITS-1:0] key_raw;
    logic [KEY_BITS-1:0]  key_scaled;
    logic                 in_bounds;
    logic                 fractional;
    logic                 up_nat;

    assign advance    = !front_valid_reg || !q_stat.full;
    assign cand_stall = !advance;
    assign accept     = cand_valid && advance;

    always_comb
    begin
        frac      = cand.lp_value[FRAC_BITS-1:0];
        frac_ext  = {1'b0, frac};
        dist_near = (frac < HALF) ? frac_ext : (ONE - frac_ext);
        in_bounds = !(cand.lp_value < cand.lower_bound)
                    && !(cand.lp_value > cand.upper_bound);
        fractional = TOL_CMP_W'(dist_near) > TOL_CMP_W'(tolerance);

        if (cand.down_locks < cand.up_locks)
            up_nat = 1'b0;
        else if (cand.down_locks > cand.up_locks)
            up_nat = 1'b1;
        else
            up_nat = (frac >= HALF);

        key_raw    = up_nat ? (ONE - frac_ext) : frac_ext;
        key_scaled = KEY_BITS'(key_raw) * KEY_BITS'(KEY_SCALE);

        front_next.cand   = cand.heuristic_integer && in_bounds && fractional;
        front_next.both   = (cand.down_locks != '0) && (cand.up_locks != '0);
        front_next.up     = up_nat;
        front_next.key    = cand.binary_flag ? KEY_BITS'(key_raw) : key_scaled;
        front_next.locks  = up_nat ? cand.up_locks : cand.down_locks;
        front_next.prio   = cand.item_priority;
        front_next.dir    = cand.direction_code;
        front_next.column = cand.column_index;
        front_next.last   = cand.last_item;

        // drop words that neither rank nor close the scan
        front_valid_next = accept && (front_next.cand || front_next.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (advance)
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_reg <= front_next;
    end

    assign push      = front_valid_reg && !q_stat.full;
    assign push_word = front_reg;

endmodule

@@ design/dbvs_queue.sv @@
// ---------------------------------------------------------------------------
// dbvs_queue: classified-candidate queue
// Small FIFO that decouples the classifier from the ranking stage.
// ---------------------------------------------------------------------------
module dbvs_queue
    import dbvs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_t      push_word,
    input  logic      pop,
    output cls_t      head,
    output q_status_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cls_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

endmodule

@@ design/dbvs_back.sv @@
// ---------------------------------------------------------------------------
// dbvs_back: running-best ranking stage
// Applies the doubly-locked filter and priorities, keeps the best
// candidate and emits the result word on the last candidate.
// ---------------------------------------------------------------------------
module dbvs_back
    import dbvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      prio_en,
    input  cls_t      head,
    input  q_status_t q_stat,
    output logic      pop,
    output logic      res_valid,
    input  logic      res_stall,
    output result_t   res
);

    logic                   triv_reg;
    logic                   triv_next;
    logic [RANK_BITS-1:0]   best_lock_reg;
    logic [RANK_BITS-1:0]   best_lock_next;
    logic [KEY_BITS-1:0]    best_key_reg;
    logic [KEY_BITS-1:0]    best_key_next;
    logic [RANK_BITS-1:0]   best_prio_reg;
    logic [RANK_BITS-1:0]   best_prio_next;
    logic [COLUMN_BITS-1:0] col_reg;
    logic [COLUMN_BITS-1:0] col_next;
    logic                   up_reg;
    logic                   up_next;
    logic                   have_reg;
    logic                   have_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    result_t                res_reg;
    result_t                res_next;
    logic                   proc;
    logic                   close;
    logic                   cand_up;
    logic [RANK_BITS-1:0]   cand_locks;
    logic [RANK_BITS-1:0]   cand_prio;
    logic                   wins;

    // hold a last word while the previous result still waits
    assign pop   = !q_stat.empty && (!head.last || !res_valid_reg || !res_stall);
    assign proc  = pop && head.cand && (triv_reg || head.both);
    assign close = pop && head.last;

    always_comb
    begin
        triv_next      = triv_reg;
        best_lock_next = best_lock_reg;
        best_key_next  = best_key_reg;
        best_prio_next = best_prio_reg;
        col_next       = col_reg;
        up_next        = up_reg;
        have_next      = have_reg;
        cand_up        = head.up;
        cand_locks     = {1'b0, head.locks};
        cand_prio      = {1'b0, head.prio};
        wins           = 1'b0;

        if (proc)
        begin
            // first doubly-locked candidate restarts the ranking
            if (triv_reg && head.both)
            begin
                triv_next      = 1'b0;
                best_lock_next = RANK_SENT;
                best_key_next  = KEY_SENT;
            end
            if (prio_en)
            begin
                if (head.dir[DIR_FORCE])
                    cand_up = head.dir[DIR_UP];
                if (cand_prio > best_prio_reg)
                    cand_locks = RANK_SENT;
                else if (cand_prio < best_prio_reg)
                begin
                    best_prio_next = cand_prio;
                    best_lock_next = RANK_SENT;
                end
            end
            wins = (cand_locks < best_lock_next)
                   || ((cand_locks == best_lock_next) && (head.key < best_key_next));
            if (wins)
            begin
                col_next       = head.column;
                best_lock_next = cand_locks;
                best_key_next  = head.key;
                up_next        = cand_up;
                have_next      = 1'b1;
            end
        end

        res_next.found                   = have_next;
        res_next.best_column             = have_next ? col_next : '0;
        res_next.round_up                = have_next && up_next;
        res_next.all_trivially_roundable = triv_next;

        if (close)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;

        if (close)
        begin
            triv_next      = 1'b1;
            best_lock_next = RANK_SENT;
            best_key_next  = KEY_SENT;
            best_prio_next = RANK_SENT;
            col_next       = '0;
            up_next        = 1'b0;
            have_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triv_reg      <= 1'b1;
            best_lock_reg <= RANK_SENT;
            best_key_reg  <= KEY_SENT;
            best_prio_reg <= RANK_SENT;
            col_reg       <= '0;
            up_reg        <= 1'b0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            triv_reg      <= triv_next;
            best_lock_reg <= best_lock_next;
            best_key_reg  <= best_key_next;
            best_prio_reg <= best_prio_next;
            col_reg       <= col_next;
            up_reg        <= up_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
